@@ sv/djs_pkg.sv @@
// ============================================================================
// djs_pkg - shared types and constants for the dot product Jaccard scorer
// Holds the transaction payload structs, the controller state type and the
// command and status bundles that join the controller to the datapath.
// ============================================================================
package djs_pkg;

   // Defaults for the top-level parameters.
   localparam int DJS_MAX_LENGTH          = 4096;
   localparam int DJS_NORM_FRACTION_BITS  = 16;
   localparam int DJS_SCORE_FRACTION_BITS = 16;

   // Fixed field widths.
   localparam int ELEM_W     = 32;
   localparam int NORM_W     = 56;
   localparam int SUM_W      = NORM_W + 1;
   localparam int ACC_W      = 64;
   localparam int DOT_W      = ACC_W - 1;
   localparam int LEN_W      = 13;
   localparam int FRAC_OUT_W = 17;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = $clog2(DOT_W + 1);

   localparam logic [LEN_W-1:0] LEN_RESET = 13'd1024;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bit of paddr.
   localparam logic [0:0] REG_VECTOR_LENGTH = 1'b0;

   typedef struct packed {
      logic signed [ELEM_W-1:0] query_element;
      logic signed [ELEM_W-1:0] candidate_element;
      logic                     last_element;
      logic [NORM_W-1:0]        query_norm_sq;
      logic [NORM_W-1:0]        candidate_norm_sq;
      logic                     is_self_pair;
   } djs_req_type;

   typedef struct packed {
      logic                  pair_exists;
      logic [FRAC_OUT_W-1:0] jaccard_fraction;
      logic [BYTE_W-1:0]     jaccard_byte;
   } djs_rsp_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_SETUP,
      ST_DIV_INTER,
      ST_THRESH,
      ST_CHECK,
      ST_DIV_FRAC,
      ST_OUTPUT
   } djs_state_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic div_step;
      logic mul_step;
      logic thresh;
      logic check;
      logic out_load;
   } djs_cmd_type;

   typedef struct packed {
      logic stage_last;
      logic skip;
      logic div_last;
      logic exists_now;
      logic big_now;
      logic out_full;
   } djs_status_type;

endpackage

@@ sv/djs_datapath.sv @@
// ============================================================================
// djs_datapath - arithmetic of the dot product Jaccard scorer
// Multiply-accumulate stage, shared restoring divider, shift-add multiplier
// for the norm sum times length, threshold compare and the result register.
// ============================================================================
module djs_datapath #(
   parameter int MAX_LENGTH          = djs_pkg::DJS_MAX_LENGTH,
   parameter int NORM_FRACTION_BITS  = djs_pkg::DJS_NORM_FRACTION_BITS,
   parameter int SCORE_FRACTION_BITS = djs_pkg::DJS_SCORE_FRACTION_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  djs_pkg::djs_req_type        req_data,
   input  logic [djs_pkg::LEN_W-1:0]   vector_length,
   input  djs_pkg::djs_cmd_type        cmd,
   output djs_pkg::djs_status_type     status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output djs_pkg::djs_rsp_type        rsp_data
);
   import djs_pkg::*;

   localparam int NUM_W       = DOT_W + NORM_FRACTION_BITS;
   localparam int SL_W        = SUM_W + LEN_W;
   localparam int DIV_W       = (NUM_W + 1 > SL_W + 1) ? NUM_W + 1 : SL_W + 1;
   localparam int INTER20_W   = DOT_W + 5;
   localparam int THR_W       = INTER20_W + NORM_FRACTION_BITS;
   localparam int FRAC_W      = SCORE_FRACTION_BITS + 1;
   localparam int BYTE_CALC_W = FRAC_W + BYTE_W + 1;

   // Product stage.
   logic signed [ELEM_W-1:0] q_el;
   logic signed [ELEM_W-1:0] c_el;
   logic signed [ACC_W-1:0]  prod_full;
   logic                     stage_valid_ff;
   logic [ACC_W-1:0]         prod_ff;
   logic                     stage_last_ff;
   logic [SUM_W-1:0]         stage_sum_ff;
   logic                     stage_self_ff;

   // Accumulator and the captured vector pair.
   logic [ACC_W-1:0]         acc_ff;
   logic [ACC_W-1:0]         acc_sum;
   logic [ACC_W-1:0]         dot_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic                     self_ff;
   logic [LEN_W-1:0]         len_eff;

   // Divider.
   logic [DIV_W-1:0]         rem_ff;
   logic [DIV_W-1:0]         den_ff;
   logic [DIV_W-1:0]         rem_sh;
   logic [DIV_W-1:0]         rem_diff;
   logic                     rem_ge;
   logic [DOT_W-1:0]         dvd_ff;
   logic [DOT_W-1:0]         quot_ff;
   logic [CNT_W-1:0]         cnt_ff;

   // Multiplier for sum times length.
   logic [SL_W-1:0]          mcand_ff;
   logic [LEN_W-1:0]         mplier_ff;
   logic [SL_W-1:0]          slprod_ff;

   // Decision and result.
   logic [INTER20_W-1:0]     inter20_ff;
   logic [THR_W-1:0]         thr_lhs;
   logic [DIV_W-1:0]         nn;
   logic [DIV_W-1:0]         sl_ext;
   logic [DIV_W-1:0]         den_frac;
   logic                     exists_ff;
   logic                     big_ff;
   logic [FRAC_W-1:0]        frac_val;
   logic [BYTE_CALC_W-1:0]   byte_calc;
   logic [BYTE_W-1:0]        byte_val;
   logic                     rsp_valid_ff;
   djs_rsp_type              rsp_data_ff;

   assign q_el      = req_data.query_element;
   assign c_el      = req_data.candidate_element;
   assign prod_full = q_el * c_el;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= cmd.accept;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prod_ff       <= prod_full;
         stage_last_ff <= req_data.last_element;
         stage_sum_ff  <= SUM_W'(req_data.query_norm_sq) + SUM_W'(req_data.candidate_norm_sq);
         stage_self_ff <= req_data.is_self_pair;
      end
   end

   // The accumulator wraps modulo 2^64 and is cleared as the last pair folds in.
   assign acc_sum = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (stage_valid_ff) begin
         acc_ff <= stage_last_ff ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff && stage_last_ff) begin
         dot_ff  <= acc_sum;
         sum_ff  <= stage_sum_ff;
         self_ff <= stage_self_ff;
      end
   end

   // A zero length counts as one; a length above the maximum saturates.
   assign len_eff = (vector_length == '0) ? LEN_W'(1) :
                    (int'(vector_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : vector_length;

   // One restoring divider step per cycle.
   assign rem_sh   = {rem_ff[DIV_W-2:0], dvd_ff[DOT_W-1]};
   assign rem_ge   = (rem_sh >= den_ff);
   assign rem_diff = rem_sh - den_ff;

   assign nn       = DIV_W'(dot_ff[DOT_W-1:0]) << NORM_FRACTION_BITS;
   assign sl_ext   = DIV_W'(slprod_ff);
   assign den_frac = sl_ext - nn;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         rem_ff  <= '0;
         den_ff  <= DIV_W'(len_eff);
         dvd_ff  <= dot_ff[DOT_W-1:0];
         quot_ff <= '0;
      end else if (cmd.check) begin
         rem_ff  <= nn;
         den_ff  <= den_frac;
         dvd_ff  <= '0;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_diff : rem_sh;
         dvd_ff  <= dvd_ff << 1;
         quot_ff <= {quot_ff[DOT_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.setup) begin
         cnt_ff <= CNT_W'(DOT_W);
      end else if (cmd.check) begin
         cnt_ff <= CNT_W'(SCORE_FRACTION_BITS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // Shift-add multiply, one length bit per cycle, overlapped with the divide.
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mcand_ff  <= SL_W'(sum_ff);
         mplier_ff <= len_eff;
         slprod_ff <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            slprod_ff <= slprod_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   // Twenty times the truncated intersection, as two shifted copies.
   always_ff @(posedge clock) begin
      if (cmd.thresh) begin
         inter20_ff <= (INTER20_W'(quot_ff) << 4) + (INTER20_W'(quot_ff) << 2);
      end
   end

   assign thr_lhs = THR_W'(inter20_ff) << NORM_FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         exists_ff <= 1'b0;
         big_ff    <= 1'b0;
      end else if (cmd.check) begin
         exists_ff <= status.exists_now;
         big_ff    <= status.big_now;
      end
   end

   assign frac_val  = big_ff ? (FRAC_W'(1) << SCORE_FRACTION_BITS) : FRAC_W'(quot_ff);
   assign byte_calc = (BYTE_CALC_W'(frac_val) << BYTE_W) - BYTE_CALC_W'(frac_val)
                    + (BYTE_CALC_W'(1) << (SCORE_FRACTION_BITS - 1));
   assign byte_val  = byte_calc[SCORE_FRACTION_BITS +: BYTE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.pair_exists      <= exists_ff;
         rsp_data_ff.jaccard_fraction <= exists_ff ? FRAC_OUT_W'(frac_val) : '0;
         rsp_data_ff.jaccard_byte     <= exists_ff ? byte_val : '0;
      end
   end

   assign status.stage_last = stage_valid_ff & stage_last_ff;
   assign status.skip       = self_ff | dot_ff[ACC_W-1];
   assign status.div_last   = (cnt_ff == CNT_W'(1));
   assign status.exists_now = (thr_lhs > THR_W'(sum_ff));
   assign status.big_now    = ((nn << 1) >= sl_ext);
   assign status.out_full   = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/djs_ctrl.sv @@
// ============================================================================
// djs_ctrl - sequencer of the dot product Jaccard scorer
// Streams elements into the datapath, then walks the divide, threshold,
// fraction and output steps that each vector pair needs.
// ============================================================================
module djs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  djs_pkg::djs_status_type  status,
   output djs_pkg::djs_cmd_type     cmd
);
   import djs_pkg::*;

   djs_state_type state_ff;
   djs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (status.stage_last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = status.skip ? ST_OUTPUT : ST_DIV_INTER;
         end
         ST_DIV_INTER: begin
            if (status.div_last) begin
               state_in = ST_THRESH;
            end
         end
         ST_THRESH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.exists_now && !status.big_now) begin
               state_in = ST_DIV_FRAC;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_DIV_FRAC: begin
            if (status.div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!status.out_full) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_ACCUM: begin
            // Hold off while the last product of a pair is folding in.
            req_stall  = status.stage_last;
            cmd.accept = req_valid & ~status.stage_last;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_DIV_INTER: begin
            cmd.div_step = 1'b1;
            cmd.mul_step = 1'b1;
         end
         ST_THRESH: begin
            cmd.thresh = 1'b1;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_DIV_FRAC: begin
            cmd.div_step = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.out_load = ~status.out_full;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/dot_product_jaccard_scorer_top.sv @@
// ============================================================================
// dot_product_jaccard_scorer_top - Jaccard similarity from a dot product
// Top level: configuration register, sequencer and datapath.
// ============================================================================
//
// Usage. Element pairs of one query and one candidate vector arrive on the
// req_ channel, one transaction per pair, and are taken at up to one per
// cycle. The transaction flagged last_element also carries both squared norms
// and the self-pair flag; it produces exactly one rsp_ transaction, and no
// other transaction produces a result.
//
// After the last element is taken, its product folds into the accumulator,
// the divider forms dot / length while the norm sum is multiplied by the
// length, and the threshold is checked. A pair that exists with similarity
// below one runs the divider again for the fraction; a self pair or a
// negative dot product goes straight to the output. The cost is set by the
// shared restoring divider: 63 steps for dot / length, then one step per
// score fraction bit. Element pairs stream at one per cycle; between vector
// pairs the req_ channel stalls for the full score computation.
//
// The result sits in an output register, so the next vector pair's elements
// are taken while a result waits; a new result waits only if the previous
// one is still stalled. Reset clears the accumulator, the handshake state and
// sets vector_length to 1024. vector_length is written at APB address 0 and
// must only change while the block is idle.
//
module dot_product_jaccard_scorer_top #(
   parameter int MAX_LENGTH          = djs_pkg::DJS_MAX_LENGTH,
   parameter int NORM_FRACTION_BITS  = djs_pkg::DJS_NORM_FRACTION_BITS,
   parameter int SCORE_FRACTION_BITS = djs_pkg::DJS_SCORE_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  djs_pkg::djs_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output djs_pkg::djs_rsp_type             rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [djs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [djs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [djs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import djs_pkg::*;

   logic [LEN_W-1:0] vector_length_ff;
   logic             reg_hit;
   logic             reg_write;
   djs_cmd_type      cmd;
   djs_status_type   status;

   // The APB port never inserts wait states. The word address bit selects the
   // register; only vector_length is implemented and other words read as zero.
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_VECTOR_LENGTH);
   assign reg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & reg_hit;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(vector_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= LEN_RESET;
      end else if (reg_write) begin
         vector_length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // The sequencer owns the req_ handshake and steps the datapath.
   djs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the accumulator, divider and the rsp_ output register.
   djs_datapath #(
      .MAX_LENGTH          (MAX_LENGTH),
      .NORM_FRACTION_BITS  (NORM_FRACTION_BITS),
      .SCORE_FRACTION_BITS (SCORE_FRACTION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .vector_length (vector_length_ff),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking testbench for the dot product Jaccard scorer
// Streams element pair transactions with random gaps and random result back
// pressure, keeps its own model of the accumulator, threshold and similarity
// arithmetic, and compares every result transaction field by field against
// the oldest predicted score. The length register is swept over its extremes.
// ============================================================================
module tb_top;
   import djs_pkg::*;

   localparam int NORM_FB      = DJS_NORM_FRACTION_BITS;
   localparam int SCORE_FB     = DJS_SCORE_FRACTION_BITS;
   localparam int MAX_LEN      = DJS_MAX_LENGTH;
   // This margin covers the longest score computation.
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 6;

   localparam logic [CSR_ADDR_W-1:0] VECTOR_LENGTH_ADDR = {REG_VECTOR_LENGTH, 2'b00};

   localparam logic [ELEM_W-1:0] ELEMENT_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] ELEMENT_MIN = 32'h8000_0000;
   localparam logic [NORM_W-1:0] NORM_MAX    = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX     = {1'b0, NORM_MAX} + {1'b0, NORM_MAX};

   // How the squared norms of a vector pair are chosen relative to its dot
   // product, so that the decision boundaries are actually reached.
   typedef enum int {
      PLAN_RANDOM,
      PLAN_BAND,
      PLAN_EXIST_EDGE,
      PLAN_SAT_EDGE,
      PLAN_ZERO,
      PLAN_FULL
   } norm_plan_type;

   // Clock and reset. Reset is held at the start, then released once.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // Every input of the block starts at a known value.
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   djs_req_type           req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   djs_rsp_type           rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Scoring model state: the running dot product and the length register copy.
   logic [ACC_W-1:0] running_dot = '0;
   logic [LEN_W-1:0] length_reg  = LEN_RESET;
   djs_rsp_type      pending_scores[$];

   int error_count     = 0;
   int items_sent      = 0;
   int scores_checked  = 0;
   int present_count   = 0;
   int saturated_count = 0;
   int settings_count  = 0;
   int rsp_hold        = 0;
   bit no_idle         = 1'b0;

   dot_product_jaccard_scorer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // A zero length acts as one and anything beyond the maximum saturates.
   function automatic logic [63:0] effective_length(logic [LEN_W-1:0] setting);
      logic [63:0] len;
      len = setting;
      if (len == 0) len = 1;
      else if (len > MAX_LEN) len = MAX_LEN;
      return len;
   endfunction

   // Computes the score that the last element of a vector pair must produce.
   // All intermediate values are exact in 128 bits, so no rounding creeps in
   // apart from the truncations that the scorer itself defines.
   function automatic djs_rsp_type score_vector(logic [ACC_W-1:0] dot,
         logic [LEN_W-1:0] len_setting, logic [NORM_W-1:0] query_norm,
         logic [NORM_W-1:0] candidate_norm, logic self_pair);
      logic [63:0]  len;
      logic [127:0] sum, inter, thr, num, scaled, den, frac, byte_val;
      djs_rsp_type  score;
      score = '0;
      len   = effective_length(len_setting);
      sum   = query_norm;
      sum   = sum + candidate_norm;
      // A dot product with the top bit set reads as negative and never exists.
      if (!self_pair && !dot[ACC_W-1]) begin
         inter = dot / len;
         thr   = sum / (128'd20 << NORM_FB);
         if (inter > thr) begin
            num    = dot;
            num    = num << NORM_FB;
            scaled = sum * len;
            // The similarity reaches one once the intersection is at least
            // half of the norm sum.
            if ((num << 1) >= scaled) begin
               frac = 128'd1 << SCORE_FB;
            end else begin
               den  = scaled - num;
               frac = (num << SCORE_FB) / den;
            end
            byte_val = (frac * 255 + (128'd1 << (SCORE_FB - 1))) >> SCORE_FB;
            if (byte_val > 255) byte_val = 255;
            score.pair_exists      = 1'b1;
            score.jaccard_fraction = frac[FRAC_OUT_W-1:0];
            score.jaccard_byte     = byte_val[BYTE_W-1:0];
         end
      end
      return score;
   endfunction

   function automatic logic [127:0] rand_upto(logic [127:0] limit);
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      return r % (limit + 1);
   endfunction

   function automatic logic [NORM_W-1:0] rand_norm();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[NORM_W-1:0];
   endfunction

   // Mostly moderate positive elements so that dot products land in the
   // range where pairs can exist, with full-range values and extremes mixed in.
   function automatic logic [ELEM_W-1:0] pick_element();
      logic [ELEM_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, 2000);
         4, 5, 6:    v = $urandom_range(0, 32'h000F_FFFF);
         7, 8:       v = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0:       v = ELEMENT_MAX;
               1:       v = ELEMENT_MIN;
               2:       v = '0;
               default: v = '1;
            endcase
         end
      endcase
      if ($urandom_range(0, 5) == 0) v = -v;
      return v;
   endfunction

   function automatic norm_plan_type pick_plan();
      norm_plan_type plan;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: plan = PLAN_BAND;
         4, 5:       plan = PLAN_EXIST_EDGE;
         6, 7:       plan = PLAN_SAT_EDGE;
         8:          plan = PLAN_RANDOM;
         default:    plan = ($urandom_range(0, 1) == 0) ? PLAN_ZERO : PLAN_FULL;
      endcase
      return plan;
   endfunction

   function automatic int vector_count();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
   endfunction

   // Picks the norm sum for a given dot product. A pair exists while the sum
   // is below twenty times the intersection, and saturates while the sum is
   // at most twice the intersection; both edges are hit exactly.
   function automatic logic [SUM_W-1:0] pick_sum(logic [ACC_W-1:0] dot, norm_plan_type plan);
      logic [127:0] len, inter, exist_lim, sat_max, lo, hi, s;
      len       = effective_length(length_reg);
      inter     = dot[ACC_W-1] ? 128'd0 : dot / len;
      exist_lim = inter * (128'd20 << NORM_FB);
      sat_max   = dot[ACC_W-1] ? 128'd0 : ({64'd0, dot} << (NORM_FB + 1)) / len;
      case (plan)
         PLAN_BAND: begin
            lo = sat_max + 1;
            hi = (exist_lim == 0) ? SUM_MAX : exist_lim - 1;
            if (hi > SUM_MAX) hi = SUM_MAX;
            s = (lo > hi) ? rand_upto(hi) : lo + rand_upto(hi - lo);
         end
         PLAN_EXIST_EDGE: s = (exist_lim == 0) ? 128'd0 : exist_lim - $urandom_range(0, 1);
         PLAN_SAT_EDGE:   s = sat_max + $urandom_range(0, 1);
         PLAN_ZERO:       s = 0;
         PLAN_FULL:       s = SUM_MAX;
         default:         s = rand_upto(SUM_MAX);
      endcase
      if (s > SUM_MAX) s = SUM_MAX;
      return s[SUM_W-1:0];
   endfunction

   function automatic djs_req_type make_item(logic [ELEM_W-1:0] query, logic [ELEM_W-1:0] cand,
         logic last, logic [NORM_W-1:0] query_norm, logic [NORM_W-1:0] candidate_norm,
         logic self_pair);
      djs_req_type item;
      item.query_element     = query;
      item.candidate_element = cand;
      item.last_element      = last;
      item.query_norm_sq     = query_norm;
      item.candidate_norm_sq = candidate_norm;
      item.is_self_pair      = self_pair;
      return item;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Sends one element pair transaction. Valid rises after a random gap and
   // the payload holds until the block takes it; the scoring model is then
   // advanced with exactly what was accepted.
   task automatic send_element(input djs_req_type item);
      int                      gap;
      logic signed [ACC_W-1:0] query_wide;
      logic signed [ACC_W-1:0] cand_wide;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      query_wide  = $signed(item.query_element);
      cand_wide   = $signed(item.candidate_element);
      running_dot = running_dot + query_wide * cand_wide;
      if (item.last_element) begin
         pending_scores.insert(pending_scores.size(),
                               score_vector(running_dot, length_reg, item.query_norm_sq,
                                            item.candidate_norm_sq, item.is_self_pair));
         running_dot = '0;
      end
   endtask

   // Sends one vector pair. The leading elements carry junk norms, which the
   // block must ignore; the norms on the last element are placed against the
   // dot product that the whole pair will have.
   task automatic send_vector(int count, norm_plan_type plan, logic self_pair);
      int                      i;
      logic [ELEM_W-1:0]       query, cand;
      logic signed [ACC_W-1:0] query_wide, cand_wide;
      logic [ACC_W-1:0]        dot;
      logic [SUM_W-1:0]        s;
      logic [127:0]            lo, hi, query_norm, candidate_norm;
      for (i = 1; i < count; i++) begin
         send_element(make_item(pick_element(), pick_element(), 1'b0, rand_norm(), rand_norm(),
                                1'($urandom_range(0, 1))));
      end
      query      = pick_element();
      cand       = pick_element();
      query_wide = $signed(query);
      cand_wide  = $signed(cand);
      dot        = running_dot + query_wide * cand_wide;
      s          = pick_sum(dot, plan);
      lo             = (s > NORM_MAX) ? s - NORM_MAX : 128'd0;
      hi             = (s > NORM_MAX) ? NORM_MAX : s;
      query_norm     = lo + rand_upto(hi - lo);
      candidate_norm = s - query_norm;
      send_element(make_item(query, cand, 1'b1, query_norm[NORM_W-1:0],
                             candidate_norm[NORM_W-1:0], self_pair));
   endtask

   // Drops valid and waits until every predicted score has been received.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
   endtask

   // A non-last element produces nothing, so the block may still be busy
   // after the last result; wait out its latency before touching a register.
   task automatic wait_idle();
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == VECTOR_LENGTH_ADDR) length_reg = value[LEN_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_read_check(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] expected);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== expected)
         report_mismatch($sformatf("register read got %0h expected %0h", got, expected));
      @(posedge clock);
   endtask

   task automatic set_length(logic [LEN_W-1:0] value);
      wait_idle();
      csr_write(VECTOR_LENGTH_ADDR, value);
      csr_read_check(VECTOR_LENGTH_ADDR, length_reg);
      settings_count++;
   endtask

   // The length register must read its reset value, then hold what is written.
   task automatic test_register_access();
      wait_idle();
      csr_read_check(VECTOR_LENGTH_ADDR, LEN_RESET);
      set_length(13'd1);
      set_length('1);
      set_length(LEN_RESET);
   endtask

   // Extreme element values, self pairs, zero and negative dot products, and
   // accumulator wraparound, all at the reset length.
   task automatic test_field_extremes();
      int i;
      // Largest positive product with zero norms: the pair saturates.
      send_element(make_item(ELEMENT_MAX, ELEMENT_MAX, 1'b1, '0, '0, 1'b0));
      // Most negative squared is the largest product; norms at their maximum.
      send_element(make_item(ELEMENT_MIN, ELEMENT_MIN, 1'b1, NORM_MAX, NORM_MAX, 1'b0));
      // Opposite extremes give a negative dot product.
      send_element(make_item(ELEMENT_MIN, ELEMENT_MAX, 1'b1, '0, '0, 1'b0));
      // A self pair never exists, however strong.
      send_element(make_item(ELEMENT_MAX, ELEMENT_MAX, 1'b1, '0, '0, 1'b1));
      send_element(make_item('0, '0, 1'b1, '0, '0, 1'b0));
      // Two full products sum to 2^63, which reads as negative.
      send_element(make_item(ELEMENT_MIN, ELEMENT_MIN, 1'b0, NORM_MAX, NORM_MAX, 1'b1));
      send_element(make_item(ELEMENT_MIN, ELEMENT_MIN, 1'b1, '0, '0, 1'b0));
      // Four of them wrap the accumulator to exactly zero.
      for (i = 0; i < 3; i++)
         send_element(make_item(ELEMENT_MIN, ELEMENT_MIN, 1'b0, rand_norm(), rand_norm(), 1'b0));
      send_element(make_item(ELEMENT_MIN, ELEMENT_MIN, 1'b1, '0, '0, 1'b0));
      // A dot product below the length truncates to no intersection.
      send_element(make_item('1, '1, 1'b1, '0, '0, 1'b0));
   endtask

   // Norm sums placed on either side of the existence and saturation edges.
   task automatic test_decision_edges();
      int i;
      for (i = 0; i < 4; i++) begin
         send_vector(1, PLAN_EXIST_EDGE, 1'b0);
         send_vector(1, PLAN_SAT_EDGE, 1'b0);
         send_vector(1, PLAN_BAND, 1'b0);
      end
   endtask

   // Zero length, the smallest lengths, the maximum and values beyond it.
   task automatic test_length_extremes();
      logic [LEN_W-1:0] lengths[6];
      int               i, j;
      lengths[0] = '0;
      lengths[1] = 13'd1;
      lengths[2] = 13'd2;
      lengths[3] = LEN_W'(MAX_LEN);
      lengths[4] = LEN_W'(MAX_LEN + 1);
      lengths[5] = '1;
      for (i = 0; i < 6; i++) begin
         set_length(lengths[i]);
         for (j = 0; j < 4; j++)
            send_vector($urandom_range(1, 4), pick_plan(), $urandom_range(0, 7) == 0);
      end
   endtask

   // Phases of mostly well-formed vector pairs with random content, mixed with
   // raw random transactions that end vectors anywhere. One phase runs with
   // no idling on either side; now and then the sender waits for a full drain.
   task automatic test_random_traffic();
      int               phase, start, roll;
      logic [LEN_W-1:0] len;
      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 2))
            0:       len = LEN_W'($urandom_range(1, 64));
            1:       len = LEN_W'($urandom_range(1, MAX_LEN));
            default: len = LEN_W'($urandom_range(0, 13'h1FFF));
         endcase
         set_length(len);
         no_idle = (phase == 2);
         start   = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
               send_vector(vector_count(), pick_plan(), $urandom_range(0, 7) == 0);
            else if (roll < 97)
               send_element(make_item($urandom, $urandom, 1'($urandom_range(0, 1)), rand_norm(),
                                      rand_norm(), 1'($urandom_range(0, 1))));
            else
               hold_until_drained();
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side: compare each accepted result with the oldest prediction,
   // then choose how long the next result is held off. The countdown only
   // runs while a result is offered, so stall also sits high between results.
   always @(posedge clock) begin : score_check
      djs_rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         scores_checked++;
         if (pending_scores.size() == 0) begin
            report_mismatch("result transaction arrived with no score pending");
         end else begin
            expected = pending_scores.pop_front();
            if (rsp_data.pair_exists !== expected.pair_exists)
               report_mismatch($sformatf("pair_exists got %0d expected %0d",
                                         rsp_data.pair_exists, expected.pair_exists));
            if (rsp_data.jaccard_fraction !== expected.jaccard_fraction)
               report_mismatch($sformatf("jaccard_fraction got %0d expected %0d",
                                         rsp_data.jaccard_fraction, expected.jaccard_fraction));
            if (rsp_data.jaccard_byte !== expected.jaccard_byte)
               report_mismatch($sformatf("jaccard_byte got %0d expected %0d",
                                         rsp_data.jaccard_byte, expected.jaccard_byte));
            if (expected.pair_exists) present_count++;
            if (expected.jaccard_fraction == (1 << SCORE_FB)) saturated_count++;
         end
         rsp_hold = no_idle ? 0 : $urandom_range(0, 8);
      end else if (rsp_valid && rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   // Main sequence: reset once, then each test in turn, then the drain.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_field_extremes();
      test_decision_edges();
      test_length_extremes();
      test_random_traffic();
      wait_idle();
      $display("Checked %0d scores from %0d element transactions over %0d length settings.",
               scores_checked, items_sent, settings_count);
      $display("%0d pairs were present and %0d of them saturated; %0d mismatches.",
               present_count, saturated_count, error_count);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d scores still pending.", pending_scores.size());
      $display("tb_top failed");
      $finish;
   end

endmodule
